### design/bnti_pkg.sv
// Package for the base-N text-to-integer parser: field widths, character
// codes, register indexes, parse phase type and character class functions.
// No dependencies.
package bnti_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned WordW  = 64;
  localparam int unsigned BaseW  = 5;
  localparam int unsigned RegIdxW = 2;

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChFf    = 8'h0C;
  localparam logic [CharW-1:0] ChNl    = 8'h0A;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChVt    = 8'h0B;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;

  typedef enum logic [RegIdxW-1:0] {
    REG_ALPHA_LOW  = 2'd0,
    REG_ALPHA_HIGH = 2'd1,
    REG_BASE_SIZE  = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_index_e;

  typedef enum logic [3:0] {
    PH_SPACE = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_DONE  = 4'b1000
  } parse_phase_e;

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == ChSpace) || (c == ChFf) || (c == ChNl) ||
           (c == ChCr) || (c == ChTab) || (c == ChVt);
  endfunction

  function automatic logic is_sign(input logic [CharW-1:0] c);
    return (c == ChPlus) || (c == ChMinus);
  endfunction

endpackage

### design/bnti_if.sv
// Valid/ready channel interfaces of the base-N text-to-integer parser:
// character requests, result requests and register writes.
// Depends on bnti_pkg.
interface bnti_in_if import bnti_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface bnti_out_if import bnti_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] parsed_value;
  logic                     alphabet_ok;
  logic                     magnitude_overflow;

  modport source (output valid, output parsed_value, output alphabet_ok,
                  output magnitude_overflow, input ready);
  modport sink   (input valid, input parsed_value, input alphabet_ok,
                  input magnitude_overflow, output ready);
endinterface

interface bnti_cfg_if import bnti_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RegIdxW-1:0] reg_index;
  logic [WordW-1:0]   wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

### design/base_n_text_to_integer.sv
// Streaming base-N text-to-integer parser, top level.
// Depends on bnti_pkg and the channel interfaces in bnti_if.
// The last character passes the input register, then the result register, to
// result valid; one character per cycle unless a held result stalls the last
// character, set by the combinational multiply-add of the accumulator by the radix.
// Reset clears parse state, configuration registers and all valid flags.
module base_n_text_to_integer import bnti_pkg::*; #(
  parameter int unsigned MAX_BASE = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bnti_cfg_if.sink      cfg_i,
  bnti_in_if.sink       in_i,
  bnti_out_if.source    out_o
);

  localparam int unsigned RadixW = $clog2(MAX_BASE + 1);
  localparam int unsigned DigitW = $clog2(MAX_BASE);
  localparam int unsigned WideW  = ValueW + RadixW;

  logic [WordW-1:0] alpha_low_q, alpha_high_q;
  logic [BaseW-1:0] base_size_q;
  logic             alpha_ok_q, alpha_ok_d;

  logic             s1_valid_q;
  logic [CharW-1:0] s1_char_q;
  logic             s1_last_q;
  logic             s1_adv;
  logic             in_acc;

  parse_phase_e      phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic              ovf_q, ovf_d;

  logic              out_valid_q;
  logic [ValueW-1:0] out_value_q;
  logic              out_ok_q;
  logic              out_ovf_q;

  logic [2*WordW-1:0] alpha_w;
  logic [RadixW-1:0]  radix;
  logic               hit;
  logic [DigitW-1:0]  digit;
  logic [WideW-1:0]   wide;

  assign alpha_w = {alpha_high_q, alpha_low_q};
  assign radix   = (base_size_q > BaseW'(MAX_BASE)) ? RadixW'(MAX_BASE)
                                                     : RadixW'(base_size_q);

  // Configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_low_q  <= '0;
      alpha_high_q <= '0;
      base_size_q  <= '0;
      alpha_ok_q   <= 1'b0;
    end else begin
      alpha_ok_q <= alpha_ok_d;
      if (cfg_i.valid) begin
        unique case (reg_index_e'(cfg_i.reg_index))
          REG_ALPHA_LOW:  alpha_low_q  <= cfg_i.wdata;
          REG_ALPHA_HIGH: alpha_high_q <= cfg_i.wdata;
          REG_BASE_SIZE:  base_size_q  <= cfg_i.wdata[BaseW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    alpha_ok_d = (radix != '0);
    for (int i = 0; i < MAX_BASE; i++) begin
      if (i < int'(radix)) begin
        if (is_blank(alpha_w[i*CharW +: CharW]) || is_sign(alpha_w[i*CharW +: CharW])) begin
          alpha_ok_d = 1'b0;
        end
        for (int j = i + 1; j < MAX_BASE; j++) begin
          if (j < int'(radix) && alpha_w[j*CharW +: CharW] == alpha_w[i*CharW +: CharW]) begin
            alpha_ok_d = 1'b0;
          end
        end
      end
    end
  end

  // Input register
  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_char_q <= in_i.char_code;
      s1_last_q <= in_i.end_of_text;
    end
  end

  // Digit lookup, lowest matching index wins
  always_comb begin
    hit   = 1'b0;
    digit = '0;
    for (int i = MAX_BASE - 1; i >= 0; i--) begin
      if (i < int'(radix) && alpha_w[i*CharW +: CharW] == s1_char_q) begin
        hit   = 1'b1;
        digit = DigitW'(i);
      end
    end
  end

  assign wide = WideW'(acc_q) * WideW'(radix) + WideW'(digit);

  // Parse step
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    if (phase_d == PH_SPACE && !is_blank(s1_char_q)) begin
      phase_d = PH_SIGN;
    end
    if (phase_d == PH_SIGN) begin
      if (is_sign(s1_char_q)) begin
        if (s1_char_q == ChMinus) begin
          neg_d = !neg_d;
        end
      end else begin
        phase_d = PH_DIGIT;
      end
    end
    if (phase_d == PH_DIGIT) begin
      if (hit) begin
        ovf_d = ovf_d || (|wide[WideW-1:ValueW-1]);
        acc_d = wide[ValueW-1:0];
      end else begin
        phase_d = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        phase_q <= PH_SPACE;
        neg_q   <= 1'b0;
        acc_q   <= '0;
        ovf_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_value_q <= neg_d ? (ValueW'(0) - acc_d) : acc_d;
      out_ok_q    <= alpha_ok_q;
      out_ovf_q   <= ovf_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.parsed_value       = $signed(out_value_q);
  assign out_o.alphabet_ok        = out_ok_q;
  assign out_o.magnitude_overflow = out_ovf_q;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for base_n_text_to_integer: characters, results and
// register writes on valid/ready channels with random stalls on each side.
// Depends on bnti_pkg, the channel interfaces in bnti_if and the parser RTL.
module tb_top;
  import bnti_pkg::*;

  localparam int unsigned MaxRadix = 16;
  localparam logic [WordW-1:0] DecLow  = 64'h3736_3534_3332_3130;
  localparam logic [WordW-1:0] DecHigh = 64'h0000_0000_0000_3938;
  localparam logic [WordW-1:0] HexHigh = 64'h6665_6463_6261_3938;
  localparam int unsigned PhaseBytes = 150;
  localparam int unsigned ReportMax  = 10;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } text_byte_t;

  typedef struct packed {
    reg_index_e       idx;
    logic [WordW-1:0] data;
  } reg_write_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     ok;
    logic                     ovf;
  } parse_result_t;

  logic clk;
  logic rst_n;

  bnti_cfg_if cfg_if ();
  bnti_in_if  in_if ();
  bnti_out_if out_if ();

  base_n_text_to_integer #(.MAX_BASE(MaxRadix)) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  text_byte_t    byte_q[$];
  reg_write_t    reg_write_q[$];
  parse_result_t value_q[$];

  int unsigned bytes_issued, bytes_taken;
  int unsigned writes_issued, writes_taken;
  int unsigned byte_gap, write_gap, result_stall;
  int unsigned results_seen, mismatches, strings_sent, settings_used;
  bit          stall_enable;

  // parser state and register copies
  logic [WordW-1:0]  alpha_lo, alpha_hi;
  logic [BaseW-1:0]  radix_reg;
  parse_phase_e      parse_state;
  logic              neg_sign;
  logic [ValueW-1:0] accum;
  logic              ovf_sticky;

  // alphabet the string generator draws digits from
  logic [2*WordW-1:0] gen_alpha;
  int unsigned        gen_radix;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic blank_byte(logic [CharW-1:0] c);
    return c == ChSpace || c == ChTab || c == ChNl || c == ChVt || c == ChFf || c == ChCr;
  endfunction

  function automatic logic sign_byte(logic [CharW-1:0] c);
    return c == ChPlus || c == ChMinus;
  endfunction

  function automatic int unsigned radix_now();
    return (radix_reg > MaxRadix) ? MaxRadix : radix_reg;
  endfunction

  function automatic logic [CharW-1:0] alpha_byte(int unsigned i);
    return (i < 8) ? alpha_lo[8*i +: 8] : alpha_hi[8*(i-8) +: 8];
  endfunction

  function automatic int digit_index(logic [CharW-1:0] c);
    int unsigned i;
    for (i = 0; i < radix_now(); i++) begin
      if (alpha_byte(i) == c) return i;
    end
    return -1;
  endfunction

  function automatic logic alphabet_valid();
    int unsigned i, j;
    if (radix_now() == 0) return 1'b0;
    for (i = 0; i < radix_now(); i++) begin
      if (blank_byte(alpha_byte(i)) || sign_byte(alpha_byte(i))) return 1'b0;
      for (j = i + 1; j < radix_now(); j++) begin
        if (alpha_byte(j) == alpha_byte(i)) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic apply_write(reg_index_e idx, logic [WordW-1:0] data);
    case (idx)
      REG_ALPHA_LOW:  alpha_lo = data;
      REG_ALPHA_HIGH: alpha_hi = data;
      REG_BASE_SIZE:  radix_reg = data[BaseW-1:0];
      default: ;
    endcase
  endtask

  task automatic parse_byte(logic [CharW-1:0] c, logic last);
    int            d;
    logic [63:0]   wide;
    parse_result_t r;
    if (parse_state == PH_SPACE && !blank_byte(c)) parse_state = PH_SIGN;
    if (parse_state == PH_SIGN) begin
      if (sign_byte(c)) begin
        if (c == ChMinus) neg_sign = !neg_sign;
      end else begin
        parse_state = PH_DIGIT;
      end
    end
    if (parse_state == PH_DIGIT) begin
      d = digit_index(c);
      if (d >= 0) begin
        wide = 64'(accum) * 64'(radix_now()) + 64'(d);
        if (wide > 64'h7FFF_FFFF) ovf_sticky = 1'b1;
        accum = wide[31:0];
      end else begin
        parse_state = PH_DONE;
      end
    end
    if (last) begin
      r.value = neg_sign ? 32'd0 - accum : accum;
      r.ok    = alphabet_valid();
      r.ovf   = ovf_sticky;
      value_q.push_back(r);
      parse_state = PH_SPACE;
      neg_sign    = 1'b0;
      accum       = '0;
      ovf_sticky  = 1'b0;
    end
  endtask

  task automatic check_result(parse_result_t got);
    parse_result_t want;
    if (value_q.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportMax)
        $display("tb_top: result %0d with nothing pending (value %0d)", results_seen,
                 got.value);
      return;
    end
    want = value_q.pop_front();
    if (got.value !== want.value || got.ok !== want.ok || got.ovf !== want.ovf) begin
      mismatches++;
      if (mismatches <= ReportMax)
        $display("tb_top: result %0d: value %0d/%0d ok %b/%b ovf %b/%b (exp/act)",
                 results_seen, want.value, got.value, want.ok, got.ok, want.ovf, got.ovf);
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      alpha_lo    = '0;
      alpha_hi    = '0;
      radix_reg   = '0;
      parse_state = PH_SPACE;
      neg_sign    = 1'b0;
      accum       = '0;
      ovf_sticky  = 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        apply_write(reg_index_e'(cfg_if.reg_index), cfg_if.wdata);
        writes_taken++;
      end
      if (in_if.valid && in_if.ready) begin
        parse_byte(in_if.char_code, in_if.end_of_text);
        bytes_taken++;
      end
      if (out_if.valid && out_if.ready)
        check_result('{out_if.parsed_value, out_if.alphabet_ok, out_if.magnitude_overflow});
    end
  end

  always @(negedge clk) begin : char_drive
    text_byte_t b;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || bytes_taken == bytes_issued) begin
      if (byte_gap != 0) begin
        byte_gap--;
        in_if.valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        b = byte_q.pop_front();
        in_if.valid       <= 1'b1;
        in_if.char_code   <= b.code;
        in_if.end_of_text <= b.last;
        bytes_issued++;
        if (stall_enable && $urandom_range(0, 7) == 0) byte_gap = $urandom_range(1, 16);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : reg_drive
    reg_write_t w;
    if (!rst_n) begin
      cfg_if.valid <= 1'b0;
    end else if (!cfg_if.valid || writes_taken == writes_issued) begin
      if (write_gap != 0) begin
        write_gap--;
        cfg_if.valid <= 1'b0;
      end else if (reg_write_q.size() != 0) begin
        w = reg_write_q.pop_front();
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= w.idx;
        cfg_if.wdata     <= w.data;
        writes_issued++;
        if (stall_enable && $urandom_range(0, 3) == 0) write_gap = $urandom_range(1, 16);
      end else begin
        cfg_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (result_stall != 0) begin
      result_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (stall_enable && $urandom_range(0, 7) == 0) result_stall = $urandom_range(1, 16);
    end
  end

  function automatic logic [CharW-1:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return ChSpace;
      1: return ChTab;
      2: return ChNl;
      3: return ChVt;
      4: return ChFf;
      default: return ChCr;
    endcase
  endfunction

  function automatic logic [CharW-1:0] pick_digit();
    if (gen_radix == 0) return 8'($urandom_range(0, 255));
    return gen_alpha[8*$urandom_range(0, gen_radix - 1) +: 8];
  endfunction

  function automatic logic [2*WordW-1:0] distinct_alphabet();
    logic [2*WordW-1:0] a;
    bit                 used[256];
    int unsigned        n;
    logic [CharW-1:0]   c;
    a = '0;
    n = 0;
    while (n < MaxRadix) begin
      c = 8'($urandom_range(0, 255));
      if (!used[c] && !blank_byte(c) && !sign_byte(c)) begin
        used[c] = 1'b1;
        a[8*n +: 8] = c;
        n++;
      end
    end
    return a;
  endfunction

  task automatic queue_text(logic [CharW-1:0] txt[$]);
    text_byte_t b;
    foreach (txt[i]) begin
      b.code = txt[i];
      b.last = (i == txt.size() - 1);
      byte_q.push_back(b);
    end
    strings_sent++;
  endtask

  task automatic queue_random_text(output int unsigned n);
    logic [CharW-1:0] txt[$];
    int unsigned      k;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 10)) txt.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) txt.push_back(pick_blank());
      repeat ($urandom_range(0, 3)) txt.push_back($urandom_range(0, 1) ? ChPlus : ChMinus);
      k = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 10);
      repeat (k) txt.push_back(pick_digit());
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(0, 255)));
      if (txt.size() == 0) txt.push_back(pick_digit());
      if ($urandom_range(0, 9) == 0)
        txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
    end
    n = txt.size();
    queue_text(txt);
  endtask

  task automatic load_alphabet(logic [WordW-1:0] lo, logic [WordW-1:0] hi,
                               logic [BaseW-1:0] size);
    reg_write_q.push_back('{REG_ALPHA_LOW, lo});
    reg_write_q.push_back('{REG_ALPHA_HIGH, hi});
    reg_write_q.push_back('{REG_BASE_SIZE, WordW'(size)});
    gen_alpha = {hi, lo};
    gen_radix = (size > MaxRadix) ? MaxRadix : size;
    settings_used++;
    while (reg_write_q.size() != 0 || writes_taken != writes_issued) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || bytes_taken != bytes_issued || value_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [CharW-1:0]   txt[$];
    logic [2*WordW-1:0] a;
    logic [BaseW-1:0]   size;
    int unsigned        n, k, pos;
    cfg_if.valid       = 1'b0;
    cfg_if.reg_index   = REG_ALPHA_LOW;
    cfg_if.wdata       = '0;
    in_if.valid        = 1'b0;
    in_if.char_code    = '0;
    in_if.end_of_text  = 1'b0;
    out_if.ready       = 1'b0;
    stall_enable       = 1'b1;
    rst_n              = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    load_alphabet(DecLow, DecHigh, 5'd10);
    txt = '{ChSpace, ChTab, ChNl, ChVt, ChFf, ChCr, ChMinus, ChPlus, ChMinus, ChMinus,
            "1", "2", "x", "5"};
    queue_text(txt);
    txt = '{ChMinus, "2", "1", "4", "7", "4", "8", "3", "6", "4", "8"};
    queue_text(txt);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      a = distinct_alphabet();
      case (p)
        0: begin
          a = {HexHigh, DecLow};
          size = 5'd16;
          reg_write_q.push_back('{REG_UNUSED, {$urandom, $urandom}});
        end
        1: begin
          a[15:0] = 16'h3130;
          size = 5'd2;
        end
        2: size = 5'($urandom_range(2, 16));
        3: size = 5'd31;
        4: size = 5'd0;
        5: begin
          size = 5'($urandom_range(2, 16));
          case ($urandom_range(0, 2))
            0: a[8*$urandom_range(0, size - 1) +: 8] = pick_blank();
            1: a[8*$urandom_range(0, size - 1) +: 8] = $urandom_range(0, 1) ? ChPlus : ChMinus;
            default: begin
              pos = $urandom_range(1, size - 1);
              a[8*pos +: 8] = a[7:0];
            end
          endcase
        end
        6: begin
          a = {{WordW{1'b0}}, {WordW{1'b1}}};
          size = 5'd16;
        end
        7: size = 5'd1;
        default: begin
          a = {DecHigh, DecLow};
          size = 5'd10;
          stall_enable = 1'b0;
        end
      endcase
      load_alphabet(a[WordW-1:0], a[2*WordW-1:WordW], size);
      n = 0;
      while (n < PhaseBytes) begin
        queue_random_text(k);
        n += k;
      end
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (value_q.size() != 0) mismatches += value_q.size();
    $display("tb_top: %0d strings of %0d characters parsed under %0d alphabet settings",
             strings_sent, bytes_taken, settings_used);
    $display("tb_top: %0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: timeout with %0d results pending", value_q.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

### sim.f
design/bnti_pkg.sv
design/bnti_if.sv
design/base_n_text_to_integer.sv
tb/tb_top.sv
